[sv/phong_shading_unit_defines.svh]
// ----------------------------------------------------------------------------
// Phong shading unit assertion macros
// Shared concurrent assertion forms, clocked on clk, held off in reset.
// ----------------------------------------------------------------------------
`ifndef PHONG_SHADING_UNIT_DEFINES_SVH
`define PHONG_SHADING_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define PSU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define PSU_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define PSU_ASSERT_IMP(lbl, ante, cons)
`define PSU_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[sv/psu_pkg.sv]
// ----------------------------------------------------------------------------
// Phong shading unit package
// Beat types and default sizing shared by the shading pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package psu_pkg;

    localparam int PSU_COMPONENT_BITS = 16;

    typedef struct packed {
        logic [47:0] normal_vec;
        logic [47:0] light_dir;
        logic [47:0] view_dir;
        logic [15:0] diffuse_gain;
        logic [15:0] specular_gain;
        logic [47:0] surface_color;
        logic [47:0] lamp_color;
        logic [15:0] lamp_intensity;
    } psu_in_t;

    typedef struct packed {
        logic [15:0] red_out;
        logic [15:0] green_out;
        logic [15:0] blue_out;
        logic        clipped;
    } psu_out_t;

endpackage

`default_nettype wire

[sv/psu_sqrt.sv]
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One root bit per stage, digit-by-digit, floor result after W stages.
// ----------------------------------------------------------------------------
`default_nettype none

module psu_sqrt #(
    parameter int W = 16
) (
    input  logic           clk,
    input  logic           en,
    input  logic [2*W-1:0] x,
    output logic [W-1:0]   root
);

    logic [W+2:0]   rem_reg  [W];
    logic [W-1:0]   root_reg [W];
    logic [2*W-1:0] xr_reg   [W];

    logic [W+2:0]   rem_next  [W];
    logic [W-1:0]   root_next [W];
    logic [2*W-1:0] xr_next   [W];

    always_comb
    begin
        logic [W+2:0]   rin;
        logic [W-1:0]   qin;
        logic [2*W-1:0] xin;
        logic [W+2:0]   sh;
        logic [W+2:0]   trial;
        for (int i = 0; i < W; i++)
        begin
            rin   = (i == 0) ? '0 : rem_reg[(i == 0) ? 0 : i-1];
            qin   = (i == 0) ? '0 : root_reg[(i == 0) ? 0 : i-1];
            xin   = (i == 0) ? x  : xr_reg[(i == 0) ? 0 : i-1];
            sh    = {rin[W:0], xin[2*W-1 -: 2]};
            trial = (W+3)'({qin, 2'b01});
            xr_next[i] = {xin[2*W-3:0], 2'b00};
            if (sh >= trial)
            begin
                rem_next[i]  = sh - trial;
                root_next[i] = {qin[W-2:0], 1'b1};
            end
            else
            begin
                rem_next[i]  = sh;
                root_next[i] = {qin[W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < W; i++)
            begin
                rem_reg[i]  <= rem_next[i];
                root_reg[i] <= root_next[i];
                xr_reg[i]   <= xr_next[i];
            end
        end
    end

    assign root = root_reg[W-1];

endmodule

`default_nettype wire

[sv/phong_shading_unit.sv]
// ----------------------------------------------------------------------------
// Phong shading unit
// Per-hit diffuse plus specular radiance in fixed point, fully pipelined.
// ----------------------------------------------------------------------------
//   channel  signals                      beat
//   input    in_valid/in_ready/in_data    one shading request
//   output   out_valid/out_ready/out_data one RGB radiance and clip flag
//
// One beat enters per cycle while the skid register is empty; the
// pipeline depth is set by the one-bit-per-stage square root.
// Reset clears all valid bits and the skid full flag.
// A stalled output parks one beat in the skid register; the pipeline
// then holds until it drains.
// ----------------------------------------------------------------------------
`default_nettype none
`include "phong_shading_unit_defines.svh"

module phong_shading_unit #(
    parameter int COMPONENT_BITS = psu_pkg::PSU_COMPONENT_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  psu_pkg::psu_in_t   in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output psu_pkg::psu_out_t  out_data
);

    import psu_pkg::*;

    localparam int CB    = COMPONENT_BITS;
    localparam int F     = CB - 2;
    localparam int EXT_W = (3 * CB > 48) ? 3 * CB : 48;
    localparam int PW    = 2 * CB;
    localparam int SUM_W = 2 * CB + 2;
    localparam int DW    = F + 3;
    localparam int W     = F + 2;
    localparam int NN_W  = 2 * DW;
    localparam int Q_W   = 2 * DW + 1;

    typedef struct packed {
        logic [W-1:0] nlc;
        logic [25:0]  p0;
        logic [25:0]  p1;
        logic [25:0]  p2;
        logic [15:0]  kd;
        logic [15:0]  ks;
    } side_t;

    logic skid_full_reg;
    logic en;
    assign en = !skid_full_reg;

    // stage 1: component and color products
    logic signed [PW-1:0] prod_reg [9];
    logic [31:0]          ls_reg [3];
    logic [15:0]          kd1_reg, ks1_reg, int1_reg;
    logic                 v1_reg;

    logic [EXT_W-1:0]     ext [3];
    logic signed [CB-1:0] comp [3][3];
    logic signed [PW-1:0] prod_next [9];

    always_comb
    begin
        ext[0] = EXT_W'(in_data.normal_vec);
        ext[1] = EXT_W'(in_data.light_dir);
        ext[2] = EXT_W'(in_data.view_dir);
        for (int v = 0; v < 3; v++)
            for (int i = 0; i < 3; i++)
                comp[v][i] = signed'(ext[v][i*CB +: CB]);
        for (int i = 0; i < 3; i++)
        begin
            prod_next[i]   = comp[0][i] * comp[1][i];
            prod_next[3+i] = comp[0][i] * comp[2][i];
            prod_next[6+i] = comp[1][i] * comp[2][i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 9; i++)
                prod_reg[i] <= prod_next[i];
            for (int c = 0; c < 3; c++)
                ls_reg[c] <= in_data.lamp_color[16*c +: 16] * in_data.surface_color[16*c +: 16];
            kd1_reg  <= in_data.diffuse_gain;
            ks1_reg  <= in_data.specular_gain;
            int1_reg <= in_data.lamp_intensity;
        end
    end

    // stage 2: dot products, lamp power
    localparam logic signed [SUM_W-1:0] POS_LIM = SUM_W'(1) << (F + 1);
    localparam logic signed [SUM_W-1:0] NEG_LIM = -POS_LIM;

    logic signed [DW-1:0] dot2_reg [3];
    logic [25:0]          p2_reg [3];
    logic [15:0]          kd2_reg, ks2_reg;
    logic                 v2_reg;

    logic signed [SUM_W-1:0] dsum [3];
    logic signed [DW-1:0]    dot_next [3];
    logic [47:0]             lsi [3];

    always_comb
    begin
        for (int d = 0; d < 3; d++)
        begin
            dsum[d] = SUM_W'(prod_reg[3*d] >>> F) + SUM_W'(prod_reg[3*d+1] >>> F)
                    + SUM_W'(prod_reg[3*d+2] >>> F);
            if (dsum[d] > POS_LIM)
                dot_next[d] = DW'(POS_LIM);
            else if (dsum[d] < NEG_LIM)
                dot_next[d] = DW'(NEG_LIM);
            else
                dot_next[d] = DW'(dsum[d]);
        end
        for (int c = 0; c < 3; c++)
            lsi[c] = ls_reg[c] * int1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int d = 0; d < 3; d++)
                dot2_reg[d] <= dot_next[d];
            for (int c = 0; c < 3; c++)
                p2_reg[c] <= lsi[c][47:22];
            kd2_reg <= kd1_reg;
            ks2_reg <= ks1_reg;
        end
    end

    // stage 3: NL times NV
    logic signed [NN_W-1:0] nn3_reg;
    logic signed [DW-1:0]   nl3_reg, lv3_reg;
    logic [25:0]            p3_reg [3];
    logic [15:0]            kd3_reg, ks3_reg;
    logic                   v3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nn3_reg <= dot2_reg[0] * dot2_reg[1];
            nl3_reg <= dot2_reg[0];
            lv3_reg <= dot2_reg[2];
            p3_reg  <= p2_reg;
            kd3_reg <= kd2_reg;
            ks3_reg <= ks2_reg;
        end
    end

    // stage 4: R.V, clamps
    localparam logic signed [Q_W-1:0] RV_MAX = Q_W'(1) << (F + 2);

    logic [DW-1:0] rv4_reg;
    side_t         side4_reg;
    logic          v4_reg;

    logic signed [Q_W-1:0] rv_raw;
    logic [DW-1:0]         rv_next;
    side_t                 side_next;

    always_comb
    begin
        rv_raw = Q_W'(nn3_reg >>> (F - 1)) - Q_W'(lv3_reg);
        if (rv_raw < 0)
            rv_next = '0;
        else if (rv_raw > RV_MAX)
            rv_next = DW'(RV_MAX);
        else
            rv_next = DW'(rv_raw);
        side_next.nlc = nl3_reg[DW-1] ? '0 : nl3_reg[W-1:0];
        side_next.p0  = p3_reg[0];
        side_next.p1  = p3_reg[1];
        side_next.p2  = p3_reg[2];
        side_next.kd  = kd3_reg;
        side_next.ks  = ks3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rv4_reg   <= rv_next;
            side4_reg <= side_next;
        end
    end

    // square root stages
    logic [W-1:0] sq_root;
    side_t        sq_side_reg [W];
    logic         sq_v_reg [W];

    psu_sqrt #(
        .W (W)
    ) u_sqrt (
        .clk  (clk),
        .en   (en),
        .x    ((2*W)'({rv4_reg, {F{1'b0}}})),
        .root (sq_root)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_side_reg[0] <= side4_reg;
            for (int i = 1; i < W; i++)
                sq_side_reg[i] <= sq_side_reg[i-1];
        end
    end

    // stage 5: gain term
    logic [18:0] term5_reg;
    logic [25:0] p5_reg [3];
    logic        v5_reg;

    side_t        sd;
    logic [F+18:0] gsum;

    always_comb
    begin
        sd   = sq_side_reg[W-1];
        gsum = (F+19)'(sd.kd) * (F+19)'(sd.nlc) + (F+19)'(sd.ks) * (F+19)'(sq_root);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            term5_reg <= gsum[F+17:F-1];
            p5_reg[0] <= sd.p0;
            p5_reg[1] <= sd.p1;
            p5_reg[2] <= sd.p2;
        end
    end

    // stage 6: channel products
    logic [44:0] v6_reg [3];
    logic        v6_valid_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
                v6_reg[c] <= p5_reg[c] * term5_reg;
        end
    end

    // stage 7: saturate
    psu_out_t out7_reg;
    psu_out_t out7_next;
    logic     v7_reg;
    logic [15:0] chan [3];
    logic [2:0]  sat;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            sat[c]  = |v6_reg[c][44:40];
            chan[c] = sat[c] ? 16'hFFFF : v6_reg[c][39:24];
        end
        out7_next.red_out   = chan[0];
        out7_next.green_out = chan[1];
        out7_next.blue_out  = chan[2];
        out7_next.clipped   = |sat;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out7_reg <= out7_next;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            v5_reg       <= 1'b0;
            v6_valid_reg <= 1'b0;
            v7_reg       <= 1'b0;
            for (int i = 0; i < W; i++)
                sq_v_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            v1_reg      <= in_valid;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            v4_reg      <= v3_reg;
            sq_v_reg[0] <= v4_reg;
            for (int i = 1; i < W; i++)
                sq_v_reg[i] <= sq_v_reg[i-1];
            v5_reg       <= sq_v_reg[W-1];
            v6_valid_reg <= v5_reg;
            v7_reg       <= v6_valid_reg;
        end
    end

    // output skid
    psu_out_t skid_reg;
    logic     skid_full_next;

    always_comb
    begin
        priority if (skid_full_reg)
            skid_full_next = !out_ready;
        else
            skid_full_next = v7_reg && !out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            skid_full_reg <= 1'b0;
        else
            skid_full_reg <= skid_full_next;
    end

    always_ff @(posedge clk)
    begin
        if (!skid_full_reg)
            skid_reg <= out7_reg;
    end

    assign in_ready  = en;
    assign out_valid = skid_full_reg || v7_reg;
    assign out_data  = skid_full_reg ? skid_reg : out7_reg;

    `PSU_ASSERT_IMP(a_clip_sat, out_valid && out_data.clipped, out_data.red_out == 16'hFFFF || out_data.green_out == 16'hFFFF || out_data.blue_out == 16'hFFFF)
    `PSU_ASSERT_NXT(a_skid_park, v7_reg && !out_ready && !skid_full_reg, skid_full_reg)
    `PSU_ASSERT_IMP(a_root_range, sq_v_reg[W-1], sq_root <= (W'(1) << (W - 1)))

endmodule

`default_nettype wire
